// ===== design/bkg_pkg.sv =====
// Package for the batch key group table.
// Holds table sizing, the key mixing constants and the types passed between stages.
// No dependencies.
package bkg_pkg;

    localparam int MAX_BATCHES = 16;
    localparam int IDX_W       = (MAX_BATCHES > 1) ? $clog2(MAX_BATCHES) : 1;
    localparam int CNT_W       = $clog2(MAX_BATCHES + 1);

    localparam logic [63:0] MIX_MUL    = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_ADD_P1 = 64'hBF58_476D_1CE4_E5BA;

    typedef struct packed {
        logic        start;
        logic        skip;
        logic [63:0] key;
    } bkg_mixed_t;

    typedef struct packed {
        logic [3:0]  batch_index;
        logic        new_batch;
        logic        skipped;
        logic        table_full;
        logic [63:0] batch_key;
    } bkg_result_t;

endpackage

// ===== design/bkg_if.sv =====
// Request and result channels of the batch key group table.
// Valid/ready handshake; no dependencies.
interface bkg_item_if;
    logic               valid;
    logic               ready;
    logic               start_req;
    logic        [63:0] geometry_key;
    logic signed [31:0] section_index;

    modport source (output valid, output start_req, output geometry_key,
                    output section_index, input ready);
    modport sink   (input valid, input start_req, input geometry_key,
                    input section_index, output ready);
endinterface

interface bkg_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  batch_index;
    logic        new_batch;
    logic        skipped;
    logic        table_full;
    logic [63:0] batch_key;

    modport source (output valid, output batch_index, output new_batch, output skipped,
                    output table_full, output batch_key, input ready);
    modport sink   (input valid, input batch_index, input new_batch, input skipped,
                    input table_full, input batch_key, output ready);
endinterface

// ===== design/batch_key_group_table.sv =====
// Top level of the batch key group table.
// Depends on bkg_pkg, bkg_if, bkg_mix and bkg_table.
//
// Usage:
//   item   - request channel: start_req, geometry_key, section_index.
//   result - one result per request: batch_index, new_batch, skipped,
//            table_full, batch_key.
//   A request mixes geometry_key and section_index into a 64-bit batch key
//   and looks it up among up to MAX_BATCHES stored keys; a miss appends the
//   key, or reports table_full when no entry is free. A zero geometry_key is
//   passed through as skipped. start_req empties the table first.
//   Path: multiply, product sum and mix registers, then the result register.
//   Throughput: one request per cycle while results are taken, set by the
//   split 32-bit multiply stage, mix stage and combinational parallel compare.
//   Reset empties the pipeline and the table; no clearing pass is needed.
//   When the receiver stalls, requests fill the pipeline stages and the
//   result register, then item.ready drops until results are taken.
module batch_key_group_table
    import bkg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    bkg_item_if.sink      item,
    bkg_result_if.source  result
);

    logic       mixed_valid;
    logic       down_ready;
    bkg_mixed_t mixed;

    bkg_mix u_mix (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .down_ready  (down_ready),
        .mixed_valid (mixed_valid),
        .mixed       (mixed)
    );

    bkg_table u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .mixed_valid (mixed_valid),
        .mixed       (mixed),
        .down_ready  (down_ready),
        .result      (result)
    );

endmodule

// ===== design/bkg_mix.sv =====
// Three-stage key mixing pipeline: split multiply, product sum, shift-add-xor mix.
// Depends on bkg_pkg and bkg_item_if.
module bkg_mix
    import bkg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    bkg_item_if.sink          item,
    input  logic              down_ready,
    output logic              mixed_valid,
    output bkg_mixed_t        mixed
);

    logic        v1_reg, v2_reg, v3_reg;
    logic        v1_next, v2_next, v3_next;
    logic        rdy1, rdy2, rdy3;

    logic [63:0] p00_reg, p00_next;
    logic [31:0] x0_reg, x0_next;
    logic [31:0] x1_reg, x1_next;
    logic [63:0] sa1_reg, sa1_next;
    logic        start1_reg, skip1_reg, skip1_next;

    logic [63:0] h_reg, h_next;
    logic [63:0] sa2_reg;
    logic        start2_reg, skip2_reg;

    logic [63:0] key_reg, key_next;
    logic        start3_reg, skip3_reg;

    logic [31:0] a0, a1;

    always_comb
    begin
        rdy3 = !v3_reg || down_ready;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;
        item.ready = rdy1;

        v1_next = rdy1 ? item.valid : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        v3_next = rdy3 ? v2_reg : v3_reg;

        a0 = item.geometry_key[31:0];
        a1 = item.geometry_key[63:32];
        p00_next   = a0 * MIX_MUL[31:0];
        x0_next    = a0 * MIX_MUL[63:32];
        x1_next    = a1 * MIX_MUL[31:0];
        sa1_next   = {{32{item.section_index[31]}}, item.section_index} + MIX_ADD_P1;
        skip1_next = (item.geometry_key == 64'd0);

        h_next   = p00_reg + {x0_reg + x1_reg, 32'd0};
        key_next = h_reg ^ (sa2_reg + (h_reg << 6) + (h_reg >> 2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && item.valid)
        begin
            p00_reg    <= p00_next;
            x0_reg     <= x0_next;
            x1_reg     <= x1_next;
            sa1_reg    <= sa1_next;
            start1_reg <= item.start_req;
            skip1_reg  <= skip1_next;
        end
        if (rdy2 && v1_reg)
        begin
            h_reg      <= h_next;
            sa2_reg    <= sa1_reg;
            start2_reg <= start1_reg;
            skip2_reg  <= skip1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            key_reg    <= key_next;
            start3_reg <= start2_reg;
            skip3_reg  <= skip2_reg;
        end
    end

    assign mixed_valid = v3_reg;
    assign mixed.start = start3_reg;
    assign mixed.skip  = skip3_reg;
    assign mixed.key   = key_reg;

endmodule

// ===== design/bkg_table.sv =====
// Key table: parallel compare against stored keys, append on miss while not full, result register.
// Depends on bkg_pkg and bkg_result_if.
module bkg_table
    import bkg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mixed_valid,
    input  bkg_mixed_t        mixed,
    output logic              down_ready,
    bkg_result_if.source      result
);

    logic [63:0]           key_mem [MAX_BATCHES];
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      cnt_eff;
    logic [MAX_BATCHES-1:0] hit_vec;
    logic                  hit_any;
    logic [IDX_W-1:0]      hit_idx;
    logic                  full;
    logic                  store;
    logic                  load_en;

    logic                  out_valid_reg, out_valid_next;
    bkg_result_t           res_reg, res_next;

    always_comb
    begin
        down_ready = !out_valid_reg || result.ready;
        load_en    = mixed_valid && down_ready;

        cnt_eff = mixed.start ? '0 : count_reg;
        for (int i = 0; i < MAX_BATCHES; i++)
        begin
            hit_vec[i] = (CNT_W'(i) < cnt_eff) && (key_mem[i] == mixed.key);
        end
        hit_any = |hit_vec;
        hit_idx = '0;
        for (int i = MAX_BATCHES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end

        full  = (cnt_eff == CNT_W'(MAX_BATCHES));
        store = !mixed.skip && !hit_any && !full;

        count_next = count_reg;
        if (load_en)
        begin
            count_next = store ? cnt_eff + CNT_W'(1) : cnt_eff;
        end

        res_next = '0;
        priority if (mixed.skip)
        begin
            res_next.skipped = 1'b1;
        end
        else if (hit_any)
        begin
            res_next.batch_index = 4'(hit_idx);
            res_next.batch_key   = mixed.key;
        end
        else if (!full)
        begin
            res_next.batch_index = 4'(cnt_eff[IDX_W-1:0]);
            res_next.new_batch   = 1'b1;
            res_next.batch_key   = mixed.key;
        end
        else
        begin
            res_next.table_full = 1'b1;
            res_next.batch_key  = mixed.key;
        end

        out_valid_next = load_en ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            res_reg <= res_next;
        end
        if (load_en && store)
        begin
            key_mem[cnt_eff[IDX_W-1:0]] <= mixed.key;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.batch_index = res_reg.batch_index;
    assign result.new_batch   = res_reg.new_batch;
    assign result.skipped     = res_reg.skipped;
    assign result.table_full  = res_reg.table_full;
    assign result.batch_key   = res_reg.batch_key;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BATCHES))
        else $error("batch count beyond table depth");

    a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
        load_en && store |=> count_reg != '0)
        else $error("append left the table empty");

    a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.skipped |->
            !res_reg.new_batch && !res_reg.table_full && res_reg.batch_key == 64'd0)
        else $error("skipped result carries data");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mixed_valid && hit_any |-> CNT_W'(hit_idx) < cnt_eff)
        else $error("hit on an entry beyond the fill count");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for batch_key_group_table: streams requests, predicts
// batch lookups and compares every result. Depends on bkg_pkg, bkg_if and the RTL.
module tb_top
    import bkg_pkg::*;
();

    localparam logic [63:0] MIX_OFFSET  = 64'hBF58_476D_1CE4_E5B9;
    localparam int          IDLE_LIMIT  = 1000;
    localparam int          HOLDOFF_LEN = 80;
    localparam int          RANDOM_ITEMS = 880;

    typedef struct {
        logic               start;
        logic        [63:0] geo;
        logic signed [31:0] sec;
        bit                 drain;
    } item_req_t;

    typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    bkg_item_if   item_ch();
    bkg_result_if result_ch();

    batch_key_group_table uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    item_req_t   pending_requests[$];
    bkg_result_t expected_batches[$];
    logic [63:0] table_keys[MAX_BATCHES];
    int          batches_used = 0;
    int          requests_queued = 0;
    int          requests_taken = 0;
    int          results_seen = 0;
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          req_taken = 1'b0;
    int          burst_left = 4;
    int          gap_left = 0;
    item_req_t   next_req;
    rx_mode_t    rx_mode = RX_STREAM;
    int          mode_left = 0;
    int          holdoff_left = 0;
    bit          holdoff_done = 1'b0;

    function automatic bkg_result_t assign_batch(input logic start, input logic [63:0] geo,
                                                 input logic signed [31:0] sec);
        bkg_result_t r;
        logic [63:0] h;
        logic [63:0] s;
        int          found;
        r = '0;
        found = -1;
        if (start)
            batches_used = 0;
        if (geo == 64'd0)
        begin
            r.skipped = 1'b1;
            return r;
        end
        h = geo * MIX_MUL;
        s = {{32{sec[31]}}, sec} + 64'd1;
        h = h ^ ((s + MIX_OFFSET) + (h << 6) + (h >> 2));
        r.batch_key = h;
        for (int i = 0; i < batches_used; i++)
        begin
            if (found < 0 && table_keys[i] == h)
                found = i;
        end
        if (found >= 0)
            r.batch_index = found[3:0];
        else if (batches_used < MAX_BATCHES)
        begin
            table_keys[batches_used] = h;
            r.batch_index = batches_used[3:0];
            r.new_batch = 1'b1;
            batches_used++;
        end
        else
            r.table_full = 1'b1;
        return r;
    endfunction

    task automatic queue_request(input logic start, input logic [63:0] geo,
                                 input logic [31:0] sec, input bit drain);
        item_req_t r;
        r.start = start;
        r.geo = geo;
        r.sec = sec;
        r.drain = drain;
        pending_requests.insert(pending_requests.size(), r);
        requests_queued++;
    endtask

    // request driver: bursts and gaps, hold until accepted
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_ch.valid || req_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_requests.size() == 0 ||
                         (pending_requests[0].drain && expected_batches.size() != 0))
                    item_ch.valid <= 1'b0;
                else
                begin
                    next_req = pending_requests.pop_front();
                    item_ch.valid <= 1'b1;
                    item_ch.start_req <= next_req.start;
                    item_ch.geometry_key <= next_req.geo;
                    item_ch.section_index <= next_req.sec;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 16);
                        gap_left = $urandom_range(1, 10);
                    end
                end
            end
        end
    end

    // result receiver: stall patterns plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                result_ch.ready <= 1'b0;
            end
            else if (!holdoff_done && results_seen >= 250)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_LEN;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                else
                    mode_left--;
                unique case (rx_mode)
                    RX_STREAM: result_ch.ready <= 1'b1;
                    RX_COIN:   result_ch.ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
                    RX_TOGGLE: result_ch.ready <= ~result_ch.ready;
                endcase
            end
        end
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        bkg_result_t want;
        req_taken = 1'b0;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (expected_batches.size() == 0)
                begin
                    error_count++;
                    $display("%0t unexpected result: expected none actual batch_key %h",
                             $time, result_ch.batch_key);
                end
                else
                begin
                    want = expected_batches.pop_front();
                    if (result_ch.batch_index !== want.batch_index)
                    begin
                        error_count++;
                        $display("%0t batch_index: expected %0d actual %0d", $time,
                                 want.batch_index, result_ch.batch_index);
                    end
                    if (result_ch.new_batch !== want.new_batch)
                    begin
                        error_count++;
                        $display("%0t new_batch: expected %b actual %b", $time,
                                 want.new_batch, result_ch.new_batch);
                    end
                    if (result_ch.skipped !== want.skipped)
                    begin
                        error_count++;
                        $display("%0t skipped: expected %b actual %b", $time,
                                 want.skipped, result_ch.skipped);
                    end
                    if (result_ch.table_full !== want.table_full)
                    begin
                        error_count++;
                        $display("%0t table_full: expected %b actual %b", $time,
                                 want.table_full, result_ch.table_full);
                    end
                    if (result_ch.batch_key !== want.batch_key)
                    begin
                        error_count++;
                        $display("%0t batch_key: expected %h actual %h", $time,
                                 want.batch_key, result_ch.batch_key);
                    end
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                expected_batches.insert(expected_batches.size(),
                                        assign_batch(item_ch.start_req,
                                                     item_ch.geometry_key,
                                                     item_ch.section_index));
                req_taken = 1'b1;
                requests_taken++;
            end
            if (req_taken || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [63:0] pool_geo[32];
        logic [31:0] pool_sec[32];
        logic [63:0] geo;
        logic [31:0] sec;
        int          n_keys;
        int          run_len;
        int          roll;
        int          counted;
        bit          drain;

        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.start_req = 1'b0;
        item_ch.geometry_key = '0;
        item_ch.section_index = '0;
        result_ch.ready = 1'b0;

        queue_request(1'b1, 64'd1, 32'd0, 1'b0);
        queue_request(1'b0, 64'd1, 32'd0, 1'b0);
        queue_request(1'b0, 64'd0, 32'h1234_5678, 1'b0);
        queue_request(1'b0, '1, 32'h8000_0000, 1'b0);
        queue_request(1'b0, '1, 32'h7FFF_FFFF, 1'b0);
        queue_request(1'b0, 64'd1, 32'hFFFF_FFFF, 1'b0);
        queue_request(1'b0, 64'h8000_0000_0000_0000, 32'd0, 1'b0);
        queue_request(1'b1, 64'd0, 32'd0, 1'b0);
        for (int i = 0; i <= MAX_BATCHES; i++)
            queue_request(1'b0, 64'h1000 + i, i, 1'b0);
        queue_request(1'b0, 64'h1000 + MAX_BATCHES - 1, MAX_BATCHES - 1, 1'b0);

        counted = 0;
        drain = 1'b1;
        while (counted < RANDOM_ITEMS)
        begin
            n_keys = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 24)
                                                  : $urandom_range(2, 12);
            run_len = $urandom_range(8, 48);
            for (int k = 0; k < n_keys; k++)
            begin
                pool_geo[k] = {$urandom, $urandom};
                pool_sec[k] = (k > 0 && $urandom_range(0, 3) == 0) ? pool_sec[0] : $urandom;
            end
            for (int j = 0; j < run_len; j++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 4)
                begin
                    geo = '0;
                    sec = $urandom;
                end
                else if (roll < 9)
                begin
                    geo = {$urandom, $urandom};
                    sec = $urandom;
                end
                else
                begin
                    roll = $urandom_range(0, n_keys - 1);
                    geo = pool_geo[roll];
                    sec = pool_sec[roll];
                    roll = 50;
                end
                if (geo != 64'd0)
                    counted++;
                queue_request((j == 0) || ($urandom_range(0, 99) >= 97), geo, sec, drain);
                drain = (counted == 350 || counted == 700);
            end
        end

        repeat (3) @(posedge clk);
        #3 rst_n = 1'b1;

        wait (requests_taken == requests_queued);
        wait (expected_batches.size() == 0);
        repeat (10) @(posedge clk);
        if (expected_batches.size() != 0)
        begin
            error_count++;
            $display("%0t %0d results never arrived", $time, expected_batches.size());
        end
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bkg_pkg.sv
design/bkg_if.sv
design/bkg_mix.sv
design/bkg_table.sv
design/batch_key_group_table.sv
tb/tb_top.sv
